[sv/mfde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mfde_pkg;

    localparam logic [2:0] KIND_PIXEL = 3'd0;
    localparam logic [2:0] KIND_HLINE = 3'd1;
    localparam logic [2:0] KIND_VLINE = 3'd2;
    localparam logic [2:0] KIND_RECT  = 3'd3;
    localparam logic [2:0] KIND_GLYPH = 3'd4;
    localparam logic [2:0] KIND_READ  = 3'd5;

    localparam int GLYPH_BITS = 48;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [2:0]  kind;
        logic [6:0]  pos_x;
        logic [5:0]  pos_y;
        logic [7:0]  span_w;
        logic [6:0]  span_h;
        logic [6:0]  border;
        logic        ink;
        logic [47:0] glyph_bits;
        logic        large_glyph;
        logic [9:0]  read_index;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bstat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GEN,
        ST_WRITE,
        ST_READ,
        ST_RDATA,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

[sv/mfde_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[sv/mfde_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfde_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire [95:0]           i_s_tdata,
    input  wire [2:0]            i_s_tuser,
    output logic                 o_q_valid,
    output mfde_pkg::t_cmd       o_q_cmd,
    input  mfde_pkg::t_bstat     i_stat
);
    import mfde_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        n_cmd.kind        = i_s_tuser;
        n_cmd.pos_x       = i_s_tdata[6:0];
        n_cmd.pos_y       = i_s_tdata[12:7];
        n_cmd.span_w      = i_s_tdata[20:13];
        n_cmd.span_h      = i_s_tdata[27:21];
        n_cmd.border      = i_s_tdata[34:28];
        n_cmd.ink         = i_s_tdata[35];
        n_cmd.glyph_bits  = i_s_tdata[83:36];
        n_cmd.large_glyph = i_s_tdata[84];
        n_cmd.read_index  = i_s_tdata[94:85];
        case (i_s_tuser)
            KIND_PIXEL, KIND_HLINE, KIND_VLINE, KIND_RECT, KIND_GLYPH: n_cmd.op = OP_DRAW;
            KIND_READ: n_cmd.op = OP_READ;
            default:   n_cmd.op = OP_NOP;
        endcase
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = i_stat.pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[sv/mfde_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfde_back #(
    parameter int SCREEN_WIDTH = 128,
    parameter int PAGE_COUNT   = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_valid,
    input  mfde_pkg::t_cmd    i_q_cmd,
    output mfde_pkg::t_bstat  o_stat,
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output logic [7:0]        o_m_tdata,
    output logic [0:0]        o_m_tuser
);
    import mfde_pkg::*;

    localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(STORE_BYTES - 1);
    localparam logic signed [12:0] SW_C      = 13'(SCREEN_WIDTH);
    localparam logic signed [12:0] ROWS_C    = 13'(PAGE_COUNT * 8);

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic [7:0]    r_j, n_j;
    logic [7:0]    r_a, n_a;
    logic [1:0]    r_s, n_s;
    logic [1:0]    r_sub, n_sub;
    logic          r_clip;
    logic [AW-1:0] r_addr;
    logic [7:0]    r_mask;
    logic          r_on;
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_clip;

    logic          outline;
    logic [7:0]    len;
    logic [7:0]    outer;
    logic [12:0]   ux, uy;
    logic signed [12:0] px, py;
    logic          onscreen;
    logic          has_pixel;
    logic          at_end;
    logic          pix_on;
    logic [5:0]    gbit;
    logic [AW-1:0] pix_addr;
    logic [7:0]    pix_mask;
    logic          in_range;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    mfde_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign outline  = (r_cmd.kind == KIND_RECT) && (r_cmd.border != 7'd0);
    assign in_range = 32'(r_cmd.read_index) < STORE_BYTES;
    assign out_free = !r_out_valid || i_m_tready;
    assign gbit     = 6'(GLYPH_BITS - 1) - r_j[5:0];

    // Pixel coordinates, frame store address, mask and ink of the current walk position.
    always_comb begin
        len    = 8'd0;
        outer  = 8'd1;
        ux     = {6'd0, r_cmd.pos_x};
        uy     = {7'd0, r_cmd.pos_y};
        pix_on = r_cmd.ink;
        case (r_cmd.kind)
            KIND_PIXEL: len = 8'd1;
            KIND_HLINE: begin
                len = r_cmd.span_w;
                ux  = {6'd0, r_cmd.pos_x} + {5'd0, r_j};
            end
            KIND_VLINE: begin
                len = {1'b0, r_cmd.span_h};
                uy  = {7'd0, r_cmd.pos_y} + {5'd0, r_j};
            end
            KIND_RECT: begin
                if (outline) begin
                    outer = {1'b0, r_cmd.border};
                    case (r_s)
                        2'd0: begin
                            len = r_cmd.span_w;
                            ux  = {6'd0, r_cmd.pos_x} + {5'd0, r_j};
                            uy  = {7'd0, r_cmd.pos_y} + {5'd0, r_a};
                        end
                        2'd1: begin
                            len = r_cmd.span_w;
                            ux  = {6'd0, r_cmd.pos_x} + {5'd0, r_j};
                            uy  = {7'd0, r_cmd.pos_y} + {6'd0, r_cmd.span_h}
                                  - 13'd1 - {5'd0, r_a};
                        end
                        2'd2: begin
                            len = {1'b0, r_cmd.span_h};
                            ux  = {6'd0, r_cmd.pos_x} + {5'd0, r_a};
                            uy  = {7'd0, r_cmd.pos_y} + {5'd0, r_j};
                        end
                        default: begin
                            len = {1'b0, r_cmd.span_h};
                            ux  = {6'd0, r_cmd.pos_x} + {5'd0, r_cmd.span_w}
                                  - 13'd1 - {5'd0, r_a};
                            uy  = {7'd0, r_cmd.pos_y} + {5'd0, r_j};
                        end
                    endcase
                end else begin
                    outer = {1'b0, r_cmd.span_h};
                    len   = r_cmd.span_w;
                    ux    = {6'd0, r_cmd.pos_x} + {5'd0, r_j};
                    uy    = {7'd0, r_cmd.pos_y} + {5'd0, r_a};
                end
            end
            KIND_GLYPH: begin
                len    = 8'(GLYPH_BITS);
                pix_on = ~(r_cmd.glyph_bits[gbit] ^ r_cmd.ink);
                if (r_cmd.large_glyph) begin
                    ux = {6'd0, r_cmd.pos_x} + {9'd0, r_j[5:3], 1'b0} + {12'd0, r_sub[1]};
                    uy = {7'd0, r_cmd.pos_y} + {9'd0, r_j[2:0], 1'b0} + {12'd0, r_sub[0]};
                end else begin
                    ux = {6'd0, r_cmd.pos_x} + {10'd0, r_j[5:3]};
                    uy = {7'd0, r_cmd.pos_y} + {10'd0, r_j[2:0]};
                end
            end
            default: len = 8'd0;
        endcase
        px       = $signed(ux);
        py       = $signed(uy);
        onscreen = (px >= 0) && (py >= 0) && (px < SW_C) && (py < ROWS_C);
        pix_addr = AW'(ux) + AW'(32'(uy[12:3]) * SCREEN_WIDTH);
        pix_mask = 8'd1 << uy[2:0];
        has_pixel = ({1'b0, r_j} < {1'b0, len});
        at_end    = ({1'b0, r_a} >= {1'b0, outer});
    end

    // Walk counters: sub-pixel, then run position, then segment, then outer row.
    always_comb begin
        n_j   = r_j;
        n_a   = r_a;
        n_s   = r_s;
        n_sub = r_sub;
        if ((r_cmd.kind == KIND_GLYPH) && r_cmd.large_glyph && (r_sub != 2'd3)) begin
            n_sub = r_sub + 2'd1;
        end else begin
            n_sub = 2'd0;
            if (({1'b0, r_j} + 9'd1) >= {1'b0, len}) begin
                n_j = 8'd0;
                if (outline && (r_s != 2'd3)) begin
                    n_s = r_s + 2'd1;
                end else begin
                    n_s = 2'd0;
                    n_a = r_a + 8'd1;
                end
            end else begin
                n_j = r_j + 8'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_DRAW: n_state = ST_GEN;
                        OP_READ: n_state = ST_READ;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_GEN: begin
                if (at_end) begin
                    n_state = ST_DONE;
                end else if (has_pixel && onscreen) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: n_state = ST_GEN;
            ST_READ:  n_state = ST_RDATA;
            ST_RDATA: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stat.clearing = (r_state == ST_CLEAR);
        o_stat.pop      = (r_state == ST_IDLE) && i_q_valid;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_on ? (ram_rdata | r_mask) : (ram_rdata & ~r_mask);
        ram_raddr = pix_addr;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 8'd0;
            end
            ST_WRITE: ram_we = 1'b1;
            ST_READ:  ram_raddr = AW'(r_cmd.read_index);
            default:  ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_clip      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: r_clip <= 1'b0;
                ST_GEN: begin
                    if (!at_end && has_pixel && !onscreen) begin
                        r_clip <= 1'b1;
                    end
                end
                ST_READ: begin
                    if (!in_range) begin
                        r_clip <= 1'b1;
                    end
                end
                default: r_clip <= r_clip;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cmd   <= i_q_cmd;
                r_j     <= 8'd0;
                r_a     <= 8'd0;
                r_s     <= 2'd0;
                r_sub   <= 2'd0;
                r_rdata <= 8'd0;
            end
            ST_GEN: begin
                r_j    <= n_j;
                r_a    <= n_a;
                r_s    <= n_s;
                r_sub  <= n_sub;
                r_addr <= pix_addr;
                r_mask <= pix_mask;
                r_on   <= pix_on;
            end
            ST_RDATA: r_rdata <= in_range ? ram_rdata : 8'd0;
            ST_DONE: begin
                if (out_free) begin
                    r_out_data <= r_rdata;
                    r_out_clip <= r_clip;
                end
            end
            default: r_rdata <= r_rdata;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_clip;
endmodule
`default_nettype wire

[sv/mono_framebuffer_draw_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Payload
// s        in         tuser[2:0] kind; tdata draw or read command
// m        out        tdata[7:0] read_data; tuser[0] clipped
//
// Each on-screen pixel goes through the read-modify-write loop of the frame store port
// (states ST_GEN, then ST_WRITE); each clipped or empty walk position stays in ST_GEN only.
// A read passes ST_READ and ST_RDATA; every command also passes ST_IDLE and ST_DONE.
// After reset a clearing pass writes zeros to all SCREEN_WIDTH*PAGE_COUNT bytes
// (1024 by default) before the first command runs; commands queue meanwhile.
// A two-entry queue lets input continue while the back end works or the output stalls.
module mono_framebuffer_draw_engine_core #(
    parameter int SCREEN_WIDTH = 128,
    parameter int PAGE_COUNT   = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // pos_x[6:0] pos_y[12:7] span_w[20:13] span_h[27:21] border[34:28] ink[35]
    // glyph_bits[83:36] large_glyph[84] read_index[94:85], zero pad[95]
    input  wire [95:0]  i_s_tdata,
    input  wire [2:0]   i_s_tuser,   // kind
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // read_data
    output logic [0:0]  o_m_tuser    // clipped
);
    import mfde_pkg::*;

    logic   q_valid;
    t_cmd   q_cmd;
    t_bstat stat;

    mfde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_stat     (stat)
    );

    mfde_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .PAGE_COUNT(PAGE_COUNT)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pop |-> q_valid) else $error("pop from empty queue");
    a_clear_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !stat.pop) else $error("command taken during clear");
    a_clear_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !o_m_tvalid) else $error("result during clear");
`endif
endmodule
`default_nettype wire
